### src/assert_macros.svh
// assertion macros used by the rtl core file
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### src/kcq_pkg.sv
// types, codes and the character translation table of the keyboard queue
// no dependencies
`default_nettype none

package kcq_pkg;

  localparam int CHAR_W = 8;
  localparam int MOD_W  = 2;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // modifier codes
  localparam logic [MOD_W-1:0] MOD_NONE  = 2'd0;
  localparam logic [MOD_W-1:0] MOD_CTRL  = 2'd1;
  localparam logic [MOD_W-1:0] MOD_SHIFT = 2'd2;

  // frequently used usage codes
  localparam logic [CHAR_W-1:0] KC_1      = 8'h1e;
  localparam logic [CHAR_W-1:0] KC_ENTER  = 8'h28;
  localparam logic [CHAR_W-1:0] KC_ESCAPE = 8'h29;
  localparam logic [CHAR_W-1:0] KC_BKSP   = 8'h2a;
  localparam logic [CHAR_W-1:0] KC_TAB    = 8'h2b;
  localparam logic [CHAR_W-1:0] KC_SPACE  = 8'h2c;
  localparam logic [CHAR_W-1:0] KC_SLASH  = 8'h38;
  localparam logic [CHAR_W-1:0] KC_KP_ADD = 8'h57;

  typedef struct packed {
    logic [MOD_W-1:0]  modifiers;
    logic [CHAR_W-1:0] key_code;
  } kc_report_t;

  // character to key report; later rules override earlier ones
  function automatic kc_report_t kc_translate(input logic [CHAR_W-1:0] k);
    kc_report_t r;
    r.modifiers = MOD_NONE;
    r.key_code  = '0;
    // letters, lower then upper case
    if (k >= 8'h61 && k <= 8'h7a) r.key_code = k - 8'h5d;
    if (k >= 8'h41 && k <= 8'h5a) begin r.modifiers = MOD_SHIFT; r.key_code = k - 8'h3d; end
    // control-a .. control-z
    if (k >= 8'h01 && k <= 8'h1a) begin r.modifiers = MOD_CTRL; r.key_code = k + 8'h03; end
    // digits one to nine
    if (k >= 8'h31 && k <= 8'h39) r.key_code = k - 8'h13;
    // shifted digit row
    if (k == 8'h21) begin r.modifiers = MOD_SHIFT; r.key_code = KC_1; end
    if (k == 8'h22) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h1f; end
    if (k == 8'h23) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h20; end
    if (k == 8'h24) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h21; end
    if (k == 8'h25) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h22; end
    if (k == 8'h5e) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h23; end
    if (k == 8'h26) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h24; end
    if (k == 8'h2a) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h25; end
    if (k == 8'h28) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h26; end
    if (k == 8'h40) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h1f; end
    // line feed and carriage return
    if (k == 8'h0a || k == 8'h0d) begin r.modifiers = MOD_NONE; r.key_code = KC_ENTER; end
    if (k == 8'h29) begin r.modifiers = MOD_SHIFT; r.key_code = 8'h27; end
    if (k == 8'h08) begin r.modifiers = MOD_NONE; r.key_code = KC_BKSP; end
    if (k == 8'h09) begin r.modifiers = MOD_NONE; r.key_code = KC_TAB; end
    if (k == 8'h20) begin r.modifiers = MOD_NONE; r.key_code = KC_SPACE; end
    // code only, modifier kept from earlier rules, except that | < > ? set shift
    if (k == 8'h30) r.key_code = 8'h27;
    if (k == 8'h1b) r.key_code = KC_ESCAPE;
    if (k == 8'h2d) r.key_code = 8'h2d;
    if (k == 8'h3d) r.key_code = 8'h2e;
    if (k == 8'h5b) r.key_code = 8'h2f;
    if (k == 8'h5c) r.key_code = 8'h31;
    if (k == 8'h7c) begin r.key_code = 8'h31; r.modifiers = MOD_SHIFT; end
    if (k == 8'h5d) r.key_code = 8'h32;
    if (k == 8'h3b) r.key_code = 8'h33;
    if (k == 8'h3a) r.key_code = 8'h34;
    if (k == 8'h2c) r.key_code = 8'h36;
    if (k == 8'h2e) r.key_code = 8'h37;
    if (k == 8'h2f) r.key_code = KC_SLASH;
    if (k == 8'h3c) begin r.key_code = 8'h36; r.modifiers = MOD_SHIFT; end
    if (k == 8'h3e) begin r.key_code = 8'h37; r.modifiers = MOD_SHIFT; end
    if (k == 8'h3f) begin r.key_code = KC_SLASH; r.modifiers = MOD_SHIFT; end
    if (k == 8'h2b) r.key_code = KC_KP_ADD;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/kcq_cmd_if.sv
// command channel: push or poll word with valid/ready handshake
// depends on kcq_pkg
`default_nettype none

interface kcq_cmd_if;
  import kcq_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [CHAR_W-1:0] char_byte;

  modport source (output valid, command, char_byte, input ready);
  modport sink   (input valid, command, char_byte, output ready);
endinterface

`default_nettype wire

### src/kcq_rpt_if.sv
// report channel: key report word with valid/ready handshake
// depends on kcq_pkg
`default_nettype none

interface kcq_rpt_if;
  import kcq_pkg::*;

  logic              valid;
  logic              ready;
  logic [MOD_W-1:0]  modifiers;
  logic [CHAR_W-1:0] key_code;
  logic              key_valid;
  logic              overrun;

  modport source (output valid, modifiers, key_code, key_valid, overrun, input ready);
  modport sink   (input valid, modifiers, key_code, key_valid, overrun, output ready);
endinterface

`default_nettype wire

### src/keyboard_char_queue_to_keycode_core.sv
// Keyboard character queue: a ring of QUEUE_DEPTH character bytes in one
// synchronous memory, holding at most QUEUE_DEPTH-1 characters. A push word
// stores a byte and answers in the next cycle, with overrun set when the queue
// was full (the byte is then dropped). A poll word takes the oldest byte and
// answers with its key report through the memory read register and then the
// output register; a poll of an empty queue answers in the next cycle with
// all fields zero. One word is in work at a time, and the next word is taken
// no earlier than the cycle in which the previous report leaves the output
// register.
// There is no clearing pass after reset; entries are polled only after written.
// Depends on kcq_pkg, kcq_cmd_if, kcq_rpt_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module keyboard_char_queue_to_keycode_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  kcq_cmd_if.sink  cmd,
  kcq_rpt_if.source rpt
);
  import kcq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t            state;
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic [PTR_W-1:0]  wr_succ;
  logic [PTR_W-1:0]  rd_succ;
  logic [CHAR_W-1:0] char_store [QUEUE_DEPTH];
  logic [CHAR_W-1:0] rd_data;
  kc_report_t        xlat;

  logic       out_valid;
  kc_report_t out_report;
  logic       out_key_valid;
  logic       out_overrun;

  logic in_ready;
  logic accept;
  logic q_full;
  logic q_empty;
  logic do_write;
  logic do_pop;
  logic push_drop;

  // pointer successors with wrap at the last entry
  assign wr_succ = (write_ptr == PTR_LAST) ? '0 : write_ptr + PTR_W'(1);
  assign rd_succ = (read_ptr == PTR_LAST) ? '0 : read_ptr + PTR_W'(1);
  assign q_full  = (wr_succ == read_ptr);
  assign q_empty = (write_ptr == read_ptr);

  // input handshake; state must be idle and output register free or draining
  assign in_ready  = (state == S_IDLE) && (!out_valid || rpt.ready);
  assign accept    = cmd.valid && in_ready;
  assign do_write  = accept && (cmd.command == CMD_PUSH) && !q_full;
  assign do_pop    = accept && (cmd.command == CMD_POLL) && !q_empty;
  assign push_drop = accept && (cmd.command == CMD_PUSH) && q_full;

  // character memory, read at the read pointer every cycle
  // a push never lands on an entry being read for a poll: full queue drops it, and
  // no word is accepted while a read is in flight
  always_ff @(posedge clk) begin
    if (do_write) begin
      char_store[write_ptr] <= cmd.char_byte;
    end
    rd_data <= char_store[read_ptr];
  end

  // translation of the byte just read
  assign xlat = kc_translate(rd_data);

  // control, pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_ptr     <= '0;
      read_ptr      <= '0;
      out_valid     <= 1'b0;
      out_report    <= '0;
      out_key_valid <= 1'b0;
      out_overrun   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (do_pop) begin
            // output register is free or drains in this cycle
            out_valid <= 1'b0;
            read_ptr  <= rd_succ;
            state     <= S_READ;
          end else if (accept) begin
            // push result, or poll of an empty queue
            out_valid     <= 1'b1;
            out_report    <= '0;
            out_key_valid <= 1'b0;
            out_overrun   <= push_drop;
            if (do_write) begin
              write_ptr <= wr_succ;
            end
          end else if (rpt.ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          out_valid     <= 1'b1;
          out_report    <= xlat;
          out_key_valid <= 1'b1;
          out_overrun   <= 1'b0;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.ready     = in_ready;
  assign rpt.valid     = out_valid;
  assign rpt.modifiers = out_report.modifiers;
  assign rpt.key_code  = out_report.key_code;
  assign rpt.key_valid = out_key_valid;
  assign rpt.overrun   = out_overrun;

  // output register is empty whenever a read result arrives
  `ASSERT_NEVER(a_read_into_busy_out, clk, rst, (state == S_READ) && out_valid, "read into busy out")
  // pointers stay inside the ring
  `ASSERT_NEVER(a_ptr_range, clk, rst, (write_ptr > PTR_LAST) || (read_ptr > PTR_LAST), "ptr range")
  // a dropped push leaves the write pointer alone and flags overrun
  `ASSERT_CLK(a_drop_on_full, clk, rst, push_drop |=> ($stable(write_ptr) && out_overrun), "drop")
  // a report never carries both a key and an overrun
  `ASSERT_NEVER(a_key_xor_ovr, clk, rst, out_valid && out_key_valid && out_overrun, "key and overrun")

endmodule

`default_nettype wire
